// ===== rtl/core/espe_pkg.sv =====
// Shared types, constants and helpers for the encoder step parameter editor.
package espe_pkg;

    // Default structure sizes
    localparam int unsigned NUM_SEQ_DEF     = 4;
    localparam int unsigned NUM_STEPS_DEF   = 16;
    localparam int unsigned PITCH_LIMIT_DEF = 4096;

    // Fixed field widths
    localparam int unsigned CNT_W  = 16;  // detent counters
    localparam int unsigned STEP_W = 12;  // per-detent pitch increments
    localparam int unsigned DCNT_W = 5;   // division count register
    localparam int unsigned DIV_W  = 4;   // stored division index
    localparam int unsigned VAL_W  = 12;  // reported value
    localparam int unsigned ESTEP_W = 4;  // reported step index
    localparam int unsigned BTN_W  = 5;
    localparam int unsigned PROD_W = CNT_W + STEP_W + 1;
    localparam int unsigned SUM_W  = PROD_W + 1;
    localparam int unsigned DSUM_W = CNT_W + 1;

    // Configuration registers
    localparam int unsigned PADDR_W = 4;
    localparam logic [1:0] REG_PITCH_STEP     = 2'd0;
    localparam logic [1:0] REG_TRANSPOSE_STEP = 2'd1;
    localparam logic [1:0] REG_DIVISION_COUNT = 2'd2;

    localparam logic [STEP_W-1:0] PITCH_STEP_RST     = 12'd33;
    localparam logic [STEP_W-1:0] TRANSPOSE_STEP_RST = 12'd396;
    localparam logic [DCNT_W-1:0] DIVISION_COUNT_RST = 5'd10;

    // Special buttons
    localparam logic [BTN_W-1:0] DIV_BUTTON       = 5'd16;
    localparam logic [BTN_W-1:0] TRANSPOSE_BUTTON = 5'd18;
    localparam logic [DCNT_W-1:0] MAX_DIVS        = 5'd16;

    typedef enum logic [1:0] {
        KIND_PIN     = 2'd0,
        KIND_PRESS   = 2'd1,
        KIND_RELEASE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        EK_NONE = 2'd0,
        EK_STEP = 2'd1,
        EK_DIV  = 2'd2,
        EK_TR   = 2'd3
    } t_edit_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_STEP,
        ST_DIV,
        ST_TR_CHK,
        ST_TR_WR,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic eval;
        logic mul;
        logic step_apply;
        logic div_apply;
        logic tr_chk;
        logic tr_wr;
        logic tr_scan;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic       work;
        logic       pending;
        t_edit_kind cls;
        logic       idx_last;
        logic       chk_ok;
        logic       out_free;
    } t_stat;

    // Sequence select reduced below the sequence count; value is tiny
    function automatic logic [1:0] seq_mod(input logic [1:0] v, input int unsigned n);
        logic [2:0] r;
        r = {1'b0, v};
        for (int k = 0; k < 3; k++) begin
            if (32'(r) >= n) begin
                r = 3'(32'(r) - n);
            end
        end
        return r[1:0];
    endfunction

endpackage

// ===== rtl/core/espe_ifs.sv =====
// Item channel interfaces: pin/key input items and edit result items.
interface espe_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       pin_a;
    logic       pin_b;
    logic [4:0] button;
    logic [1:0] active_seq;

    modport source (output valid, kind, pin_a, pin_b, button, active_seq, input ready);
    modport sink   (input valid, kind, pin_a, pin_b, button, active_seq, output ready);
endinterface

interface espe_out_if;
    logic        valid;
    logic        ready;
    logic        moved_event;
    logic [1:0]  edit_kind;
    logic        edit_applied;
    logic [11:0] new_value;
    logic [3:0]  edited_step;

    modport source (output valid, moved_event, edit_kind, edit_applied, new_value,
                    edited_step, input ready);
    modport sink   (input valid, moved_event, edit_kind, edit_applied, new_value,
                    edited_step, output ready);
endinterface

// ===== rtl/core/espe_ctrl.sv =====
// Sequencing state machine of the editor.
module espe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  espe_pkg::t_stat i_stat,
    output espe_pkg::t_cmd  o_cmd,
    output logic            o_in_ready
);

    espe_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= espe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            espe_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.work ? espe_pkg::ST_EVAL : espe_pkg::ST_DONE;
                end
            end
            espe_pkg::ST_EVAL: begin
                if (!i_stat.pending) begin
                    n_state = espe_pkg::ST_DONE;
                end else begin
                    case (i_stat.cls)
                        espe_pkg::EK_STEP: n_state = espe_pkg::ST_MUL;
                        espe_pkg::EK_TR:   n_state = espe_pkg::ST_MUL;
                        espe_pkg::EK_DIV:  n_state = espe_pkg::ST_DIV;
                        default:           n_state = espe_pkg::ST_DONE;
                    endcase
                end
            end
            espe_pkg::ST_MUL: begin
                n_state = (i_stat.cls == espe_pkg::EK_STEP) ? espe_pkg::ST_STEP
                                                            : espe_pkg::ST_TR_CHK;
            end
            espe_pkg::ST_STEP: n_state = espe_pkg::ST_DONE;
            espe_pkg::ST_DIV:  n_state = espe_pkg::ST_DONE;
            espe_pkg::ST_TR_CHK: begin
                if (i_stat.idx_last) begin
                    n_state = i_stat.chk_ok ? espe_pkg::ST_TR_WR : espe_pkg::ST_DONE;
                end
            end
            espe_pkg::ST_TR_WR: begin
                if (i_stat.idx_last) begin
                    n_state = espe_pkg::ST_DONE;
                end
            end
            espe_pkg::ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = espe_pkg::ST_IDLE;
                end
            end
            default: n_state = espe_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            espe_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            espe_pkg::ST_EVAL:   o_cmd.eval = 1'b1;
            espe_pkg::ST_MUL:    o_cmd.mul = 1'b1;
            espe_pkg::ST_STEP:   o_cmd.step_apply = 1'b1;
            espe_pkg::ST_DIV:    o_cmd.div_apply = 1'b1;
            espe_pkg::ST_TR_CHK: begin
                o_cmd.tr_chk  = 1'b1;
                o_cmd.tr_scan = 1'b1;
            end
            espe_pkg::ST_TR_WR: begin
                o_cmd.tr_wr   = 1'b1;
                o_cmd.tr_scan = 1'b1;
            end
            espe_pkg::ST_DONE:   o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/espe_dp.sv =====
// Datapath: encoder decode, edit arithmetic, pitch memory and result register.
module espe_dp #(
    parameter int unsigned NUM_SEQ     = espe_pkg::NUM_SEQ_DEF,
    parameter int unsigned NUM_STEPS   = espe_pkg::NUM_STEPS_DEF,
    parameter int unsigned PITCH_LIMIT = espe_pkg::PITCH_LIMIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  espe_pkg::t_cmd                    i_cmd,
    output espe_pkg::t_stat                   o_stat,
    // item fields
    input  logic [1:0]                        i_kind,
    input  logic                              i_pin_a,
    input  logic                              i_pin_b,
    input  logic [espe_pkg::BTN_W-1:0]        i_button,
    input  logic [1:0]                        i_active_seq,
    // configuration
    input  logic [espe_pkg::STEP_W-1:0]       i_pitch_step,
    input  logic [espe_pkg::STEP_W-1:0]       i_transpose_step,
    input  logic [espe_pkg::DCNT_W-1:0]       i_division_count,
    // result
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_moved_event,
    output logic [1:0]                        o_edit_kind,
    output logic                              o_edit_applied,
    output logic [espe_pkg::VAL_W-1:0]        o_new_value,
    output logic [espe_pkg::ESTEP_W-1:0]      o_edited_step
);

    localparam int unsigned DEPTH  = NUM_SEQ * NUM_STEPS;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned SEQ_W  = (NUM_SEQ > 1) ? $clog2(NUM_SEQ) : 1;
    localparam int unsigned IDX_W  = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;
    localparam int unsigned PW     = $clog2(PITCH_LIMIT);
    localparam int unsigned CW     = espe_pkg::CNT_W;

    // Encoder and edit state
    logic [CW-1:0]                    r_detent, r_applied;
    logic                             r_last_a, r_half, r_armed, r_tgt_valid, r_moved_sent;
    logic [espe_pkg::BTN_W-1:0]       r_target;
    logic [SEQ_W-1:0]                 r_seq;
    logic [espe_pkg::DIV_W-1:0]       r_div [NUM_SEQ];

    // Work registers
    logic signed [CW-1:0]             r_diff;
    logic signed [espe_pkg::PROD_W-1:0] r_prod;
    logic [IDX_W-1:0]                 r_idx;
    logic                             r_tr_ok;

    // Pending result fields
    logic                             r_res_moved, r_res_applied;
    espe_pkg::t_edit_kind             r_res_kind;
    logic [espe_pkg::VAL_W-1:0]       r_res_value;
    logic [espe_pkg::ESTEP_W-1:0]     r_res_step;

    // Result register
    logic                             r_out_valid;
    logic                             r_out_moved, r_out_applied;
    logic [1:0]                       r_out_kind;
    logic [espe_pkg::VAL_W-1:0]       r_out_value;
    logic [espe_pkg::ESTEP_W-1:0]     r_out_step;

    // Pitch memory with per-entry valid bits (invalid entries read as zero)
    logic [PW-1:0]                    r_mem [DEPTH];
    logic [DEPTH-1:0]                 r_mem_vld;
    logic [PW-1:0]                    r_rd_raw;
    logic                             r_rd_vld;

    espe_pkg::t_edit_kind             cls;
    logic                             pending, idx_last, in_range, d_ok, mem_we;
    logic [IDX_W-1:0]                 idx_nxt;
    logic [ADDR_W-1:0]                base, rd_off, wr_off, rd_addr, wr_addr;
    logic [PW-1:0]                    rd_data;
    logic signed [espe_pkg::SUM_W-1:0]  p_sum;
    logic signed [espe_pkg::PROD_W-1:0] m_a, m_b;
    logic [espe_pkg::STEP_W-1:0]      step_sel;
    logic signed [espe_pkg::DSUM_W-1:0] d_sum;
    logic [espe_pkg::DCNT_W-1:0]      div_lim;

    always_comb begin
        cls = espe_pkg::EK_NONE;
        if (r_tgt_valid) begin
            if (32'(r_target) < NUM_STEPS) begin
                cls = espe_pkg::EK_STEP;
            end else if (r_target == espe_pkg::DIV_BUTTON) begin
                cls = espe_pkg::EK_DIV;
            end else if (r_target == espe_pkg::TRANSPOSE_BUTTON) begin
                cls = espe_pkg::EK_TR;
            end
        end
    end

    assign pending  = (cls != espe_pkg::EK_NONE) && (r_detent != r_applied);
    assign idx_last = (r_idx == IDX_W'(NUM_STEPS - 1));
    assign idx_nxt  = idx_last ? '0 : r_idx + 1'b1;

    assign base    = ADDR_W'(ADDR_W'(r_seq) * ADDR_W'(NUM_STEPS));
    assign rd_off  = i_cmd.tr_scan ? ADDR_W'(idx_nxt)
                   : ((cls == espe_pkg::EK_STEP) ? ADDR_W'(r_target) : '0);
    assign wr_off  = i_cmd.tr_wr ? ADDR_W'(r_idx) : ADDR_W'(r_target);
    assign rd_addr = base + rd_off;
    assign wr_addr = base + wr_off;
    assign rd_data = r_rd_vld ? r_rd_raw : '0;

    // New pitch = stored pitch + detents * increment
    assign p_sum    = espe_pkg::SUM_W'($signed({1'b0, rd_data}))
                    + espe_pkg::SUM_W'(r_prod);
    assign in_range = !p_sum[espe_pkg::SUM_W-1]
                    && (p_sum < $signed(espe_pkg::SUM_W'(PITCH_LIMIT)));
    assign mem_we   = (i_cmd.step_apply && in_range) || i_cmd.tr_wr;

    assign step_sel = (cls == espe_pkg::EK_TR) ? i_transpose_step : i_pitch_step;
    assign m_a      = espe_pkg::PROD_W'(r_diff);
    assign m_b      = $signed(espe_pkg::PROD_W'(step_sel));

    assign div_lim = (i_division_count > espe_pkg::MAX_DIVS) ? espe_pkg::MAX_DIVS
                                                             : i_division_count;
    assign d_sum   = $signed(espe_pkg::DSUM_W'(r_div[r_seq])) + espe_pkg::DSUM_W'(r_diff);
    assign d_ok    = !d_sum[espe_pkg::DSUM_W-1]
                   && (d_sum < $signed(espe_pkg::DSUM_W'(div_lim)));

    assign o_stat.work     = (i_kind == espe_pkg::KIND_PIN) && r_armed;
    assign o_stat.pending  = pending;
    assign o_stat.cls      = cls;
    assign o_stat.idx_last = idx_last;
    assign o_stat.chk_ok   = r_tr_ok && in_range;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detent     <= '0;
            r_applied    <= '0;
            r_last_a     <= 1'b1;
            r_half       <= 1'b0;
            r_armed      <= 1'b0;
            r_tgt_valid  <= 1'b0;
            r_target     <= '0;
            r_moved_sent <= 1'b0;
            for (int s = 0; s < NUM_SEQ; s++) begin
                r_div[s] <= '0;
            end
        end else begin
            if (i_cmd.accept) begin
                case (i_kind)
                    espe_pkg::KIND_PRESS: begin
                        r_armed     <= 1'b1;
                        r_tgt_valid <= 1'b1;
                        r_target    <= i_button;
                    end
                    espe_pkg::KIND_RELEASE: begin
                        r_armed      <= 1'b0;
                        r_tgt_valid  <= 1'b0;
                        r_target     <= '0;
                        r_moved_sent <= 1'b0;
                    end
                    espe_pkg::KIND_PIN: begin
                        if (r_armed) begin
                            // two A edges per detent; B sets the direction
                            if (i_pin_a != r_last_a) begin
                                if (r_half) begin
                                    r_detent <= (i_pin_b != i_pin_a) ? r_detent - 1'b1
                                                                     : r_detent + 1'b1;
                                    r_half   <= 1'b0;
                                end else begin
                                    r_half <= 1'b1;
                                end
                            end
                            r_last_a <= i_pin_a;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.eval && pending) begin
                r_applied <= r_detent;
                if (!r_moved_sent) begin
                    r_moved_sent <= 1'b1;
                end
            end
            if (i_cmd.div_apply && d_ok) begin
                r_div[r_seq] <= d_sum[espe_pkg::DIV_W-1:0];
            end
        end
    end

    // Work and result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_seq         <= SEQ_W'(espe_pkg::seq_mod(i_active_seq, NUM_SEQ));
            r_res_moved   <= 1'b0;
            r_res_applied <= 1'b0;
            r_res_kind    <= espe_pkg::EK_NONE;
            r_res_value   <= '0;
            r_res_step    <= '0;
        end
        if (i_cmd.eval && pending) begin
            r_diff      <= $signed(r_detent - r_applied);
            r_res_moved <= !r_moved_sent;
            r_res_kind  <= cls;
            if (cls == espe_pkg::EK_STEP) begin
                r_res_step <= espe_pkg::ESTEP_W'(r_target);
            end
        end
        if (i_cmd.mul) begin
            r_prod  <= m_a * m_b;
            r_idx   <= '0;
            r_tr_ok <= 1'b1;
        end
        if (i_cmd.step_apply && in_range) begin
            r_res_applied <= 1'b1;
            r_res_value   <= espe_pkg::VAL_W'(p_sum);
        end
        if (i_cmd.div_apply && d_ok) begin
            r_res_applied <= 1'b1;
            r_res_value   <= espe_pkg::VAL_W'(d_sum[espe_pkg::DIV_W-1:0]);
        end
        if (i_cmd.tr_chk) begin
            r_idx <= idx_nxt;
            if (!in_range) begin
                r_tr_ok <= 1'b0;
            end
            if (idx_last) begin
                r_res_applied <= r_tr_ok && in_range;
            end
        end
        if (i_cmd.tr_wr) begin
            r_idx <= idx_nxt;
        end
    end

    // Pitch memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= PW'(p_sum);
        end
        r_rd_raw <= r_mem[rd_addr];
        r_rd_vld <= r_mem_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
        end else if (mem_we) begin
            r_mem_vld[wr_addr] <= 1'b1;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_moved   <= r_res_moved;
            r_out_kind    <= r_res_kind;
            r_out_applied <= r_res_applied;
            r_out_value   <= r_res_value;
            r_out_step    <= r_res_step;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_moved_event  = r_out_moved;
    assign o_edit_kind    = r_out_kind;
    assign o_edit_applied = r_out_applied;
    assign o_new_value    = r_out_value;
    assign o_edited_step  = r_out_step;

`ifndef SYNTH
    a_tr_write_checked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tr_wr |-> r_tr_ok)
        else $error("transpose write without a passing range check");
    a_applied_catches_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && pending) |=> (r_applied == r_detent))
        else $error("applied count not updated on edit");
    a_moved_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_moved_sent) |-> $past(i_cmd.eval))
        else $error("moved flag set outside edit evaluation");
    a_tr_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_kind == espe_pkg::EK_TR) |-> (r_res_value == '0))
        else $error("transpose result carries a value");
`endif

endmodule

// ===== rtl/core/encoder_step_parameter_editor.sv =====
// Top level: APB configuration registers, controller and datapath of the editor.
//
//  port      dir   flow                  payload
//  i_in      sink  valid/ready item in   kind, pin_a, pin_b, button, active_seq
//  o_out     src   valid/ready item out  moved_event, edit_kind, edit_applied,
//                                        new_value, edited_step
//  psel/...  APB   register writes/reads pitch_step, transpose_step, division_count
//
//  One item at a time; every item yields one result item.
//  Key items and unarmed pin samples go straight to DONE; armed pin samples pass EVAL first.
//  Step pitch edits pass EVAL, MUL and STEP; division edits pass EVAL and DIV.
//  Transpose passes EVAL and MUL, then scans the pitch memory through its single read port
//  (one range-check pass, then one rewrite pass if every entry is in range).
//  Reset is synchronous; pitch memory valid bits clear at once, no clearing pass.
//  A held result stays in the output register while the next item is accepted.
module encoder_step_parameter_editor #(
    parameter int unsigned NUM_SEQ     = espe_pkg::NUM_SEQ_DEF,
    parameter int unsigned NUM_STEPS   = espe_pkg::NUM_STEPS_DEF,
    parameter int unsigned PITCH_LIMIT = espe_pkg::PITCH_LIMIT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    espe_in_if.sink                      i_in,
    espe_out_if.source                   o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [espe_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [espe_pkg::STEP_W-1:0] r_pitch_step, r_transpose_step;
    logic [espe_pkg::DCNT_W-1:0] r_division_count;
    logic [1:0]                  reg_idx;
    logic                        cfg_we;

    espe_pkg::t_cmd  cmd;
    espe_pkg::t_stat stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_step     <= espe_pkg::PITCH_STEP_RST;
            r_transpose_step <= espe_pkg::TRANSPOSE_STEP_RST;
            r_division_count <= espe_pkg::DIVISION_COUNT_RST;
        end else if (cfg_we) begin
            case (reg_idx)
                espe_pkg::REG_PITCH_STEP:     r_pitch_step <= pwdata[espe_pkg::STEP_W-1:0];
                espe_pkg::REG_TRANSPOSE_STEP: begin
                    r_transpose_step <= pwdata[espe_pkg::STEP_W-1:0];
                end
                espe_pkg::REG_DIVISION_COUNT: begin
                    r_division_count <= pwdata[espe_pkg::DCNT_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            espe_pkg::REG_PITCH_STEP:     prdata = 32'(r_pitch_step);
            espe_pkg::REG_TRANSPOSE_STEP: prdata = 32'(r_transpose_step);
            espe_pkg::REG_DIVISION_COUNT: prdata = 32'(r_division_count);
            default:                      prdata = '0;
        endcase
    end

    espe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (i_in.ready)
    );

    espe_dp #(
        .NUM_SEQ     (NUM_SEQ),
        .NUM_STEPS   (NUM_STEPS),
        .PITCH_LIMIT (PITCH_LIMIT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_kind           (i_in.kind),
        .i_pin_a          (i_in.pin_a),
        .i_pin_b          (i_in.pin_b),
        .i_button         (i_in.button),
        .i_active_seq     (i_in.active_seq),
        .i_pitch_step     (r_pitch_step),
        .i_transpose_step (r_transpose_step),
        .i_division_count (r_division_count),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_moved_event    (o_out.moved_event),
        .o_edit_kind      (o_out.edit_kind),
        .o_edit_applied   (o_out.edit_applied),
        .o_new_value      (o_out.new_value),
        .o_edited_step    (o_out.edited_step)
    );

endmodule
